@@ sv/ktvt_pkg.sv @@
// ktvt_pkg: shared types and codes for the keyed typed value table.
// No dependencies.
package ktvt_pkg;

  typedef enum logic [2:0] {
    OP_SET       = 3'd0,
    OP_INT_WR    = 3'd1,
    OP_FIX_WR    = 3'd2,
    OP_GET       = 3'd3,
    OP_TTL       = 3'd4,
    OP_TICK      = 3'd5,
    OP_DIRTY_Q   = 3'd6,
    OP_DIRTY_CLR = 3'd7
  } op_t;

  localparam logic [2:0] T_NONE   = 3'd0;
  localparam logic [2:0] T_INT    = 3'd1;
  localparam logic [2:0] T_FIXED  = 3'd2;
  localparam logic [2:0] T_BOOL   = 3'd3;
  localparam logic [2:0] T_HANDLE = 3'd4;
  localparam logic [2:0] T_VEC2   = 3'd5;
  localparam logic [2:0] T_TIMER  = 3'd6;

  localparam logic [1:0] POL_SET = 2'd0;
  localparam logic [1:0] POL_MAX = 2'd1;
  localparam logic [1:0] POL_MIN = 2'd2;
  localparam logic [1:0] POL_ACC = 2'd3;

  typedef struct packed {
    op_t         op;
    logic [31:0] key;
    logic [2:0]  vtype;
    logic [1:0]  policy;
    logic [31:0] a;
    logic [31:0] b;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_RD,
    BK_EXEC,
    BK_TICK_RD,
    BK_TICK_WR,
    BK_DONE
  } bk_state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] s;
    s = {x[31], x} + {y[31], y};
    if (s[32] != s[31]) sat_add = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else sat_add = s[31:0];
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] x, input logic [31:0] y);
    logic [32:0] s;
    s = {x[31], x} - {y[31], y};
    if (s[32] != s[31]) sat_sub = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else sat_sub = s[31:0];
  endfunction

endpackage

@@ sv/ktvt_front.sv @@
// ktvt_front: takes requests, classifies them and queues them for the back end.
// Depends on ktvt_pkg.
module ktvt_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  ktvt_pkg::req_t req_in,
  output logic           busy,
  output logic           q_valid,
  output ktvt_pkg::req_t q_req,
  output logic           q_reject,
  input  logic           q_pop
);
  import ktvt_pkg::*;

  localparam int QD = 2;

  req_t        mem_r [QD];
  logic        rej_r [QD];
  logic        wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, reject_in;

  assign busy      = (cnt_r == 2'(QD));
  assign push      = start && !busy;
  // set typed with type none or an unused code fails without a lookup
  assign reject_in = (req_in.op == OP_SET) &&
                     ((req_in.vtype == T_NONE) || (req_in.vtype > T_TIMER));
  assign q_valid   = (cnt_r != 2'd0);
  assign q_req     = mem_r[rp_r];
  assign q_reject  = rej_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = q_pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= req_in;
      rej_r[wp_r] <= reject_in;
    end
  end
endmodule

@@ sv/ktvt_back.sv @@
// ktvt_back: searches the tag store and executes one queued request at a time.
// Depends on ktvt_pkg.
module ktvt_back #(
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ktvt_pkg::req_t q_req,
  input  logic           q_reject,
  output logic           q_pop,
  output logic           res_valid,
  output logic           res_ok,
  output logic [31:0]    res_a,
  output logic [31:0]    res_b,
  output logic           res_dirty
);
  import ktvt_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0] tag_mem [CAPACITY];
  logic [31:0] vx_mem  [CAPACITY];
  logic [31:0] vy_mem  [CAPACITY];
  logic [31:0] ib_mem  [CAPACITY];
  logic [31:0] fb_mem  [CAPACITY];
  logic [31:0] ttl_mem [CAPACITY];
  logic [2:0]  ty_mem  [CAPACITY];
  logic [CAPACITY-1:0] dirty_r, valid_r;

  bk_state_t   st_r, st_nxt;
  logic [CW-1:0] used_r, idx_r;
  logic [31:0] tag_q, vx_q, vy_q, ib_q, fb_q, ttl_q;
  logic [2:0]  ty_q;
  logic        found_r;
  logic        ok_r, dq_r;
  logic [31:0] ra_r, rb_r;
  logic [IW-1:0] ix;

  logic        tag_we, ent_we;
  logic [31:0] w_vx, w_vy, w_ib, w_fb, w_ttl;
  logic [2:0]  w_ty;
  logic        w_dirty;
  logic        e_ok, e_dq;
  logic [31:0] e_ra, e_rb;
  logic        add_new;

  assign ix = idx_r[IW-1:0];

  // stored fields of a never-written entry read as the reset value
  logic [31:0] cx, cy, cib, cfb, cttl;
  logic [2:0]  cty;
  logic        cv;
  assign cv   = valid_r[ix];
  assign cx   = cv ? vx_q  : 32'd0;
  assign cy   = cv ? vy_q  : 32'd0;
  assign cib  = cv ? ib_q  : 32'd0;
  assign cfb  = cv ? fb_q  : 32'd0;
  assign cttl = cv ? ttl_q : 32'd0;
  assign cty  = cv ? ty_q  : T_NONE;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_reject) st_nxt = BK_DONE;
          else if (q_req.op == OP_TICK) st_nxt = (used_r == '0) ? BK_DONE : BK_TICK_RD;
          else st_nxt = BK_SEARCH;
        end
      end
      BK_SEARCH: begin
        if (idx_r >= used_r) st_nxt = BK_RD;
        else if (tag_q == q_req.key && !(idx_r == '0 && !found_r)) st_nxt = BK_RD;
      end
      BK_RD:      st_nxt = BK_EXEC;
      BK_EXEC:    st_nxt = BK_DONE;
      BK_TICK_RD: st_nxt = BK_TICK_WR;
      BK_TICK_WR: st_nxt = (idx_r + CW'(1) >= used_r) ? BK_DONE : BK_TICK_RD;
      BK_DONE:    st_nxt = BK_IDLE;
      default:    st_nxt = BK_IDLE;
    endcase
  end

  logic hit;
  logic is_write;
  assign is_write = (q_req.op == OP_SET) || (q_req.op == OP_INT_WR) ||
                    (q_req.op == OP_FIX_WR);

  always_comb begin
    e_ok = 1'b0; e_dq = 1'b0; e_ra = '0; e_rb = '0;
    ent_we = 1'b0; tag_we = 1'b0; add_new = 1'b0;
    w_vx = cx; w_vy = cy; w_ib = cib; w_fb = cfb; w_ttl = cttl; w_ty = cty;
    w_dirty = dirty_r[ix];
    hit = found_r;
    if (st_r == BK_EXEC) begin
      if (!hit && is_write && used_r < CW'(CAPACITY)) begin
        add_new = 1'b1;
        hit = 1'b1;
        tag_we = 1'b1;
      end
      if (hit) begin
        case (q_req.op)
          OP_SET: begin
            ent_we = 1'b1;
            w_ty = q_req.vtype;
            w_vx = (q_req.vtype == T_BOOL) ? {31'd0, q_req.a != 32'd0} : q_req.a;
            if (q_req.vtype == T_VEC2)  w_vy = q_req.b;
            if (q_req.vtype == T_INT)   w_ib = q_req.a;
            if (q_req.vtype == T_FIXED) w_fb = q_req.a;
            w_dirty = 1'b1;
            e_ok = 1'b1;
          end
          OP_INT_WR, OP_FIX_WR: begin
            logic fx, ch;
            logic [31:0] cur;
            fx  = (q_req.op == OP_FIX_WR);
            cur = cx;
            if (cty != (fx ? T_FIXED : T_INT)) cur = fx ? cfb : cib;
            w_ty = fx ? T_FIXED : T_INT;
            ch = 1'b1;
            w_vx = cur;
            case (q_req.policy)
              POL_SET: w_vx = q_req.a;
              POL_MAX: begin
                ch = $signed(q_req.a) > $signed(cur);
                if (ch) w_vx = q_req.a;
              end
              POL_MIN: begin
                ch = $signed(q_req.a) < $signed(cur);
                if (ch) w_vx = q_req.a;
              end
              default: w_vx = fx ? sat_add(cur, q_req.a) : cur + q_req.a;
            endcase
            if (fx) w_fb = w_vx; else w_ib = w_vx;
            if (ch) w_dirty = 1'b1;
            ent_we = 1'b1;
            e_ok = fx ? ch : 1'b1;
          end
          OP_GET: begin
            if (q_req.vtype != T_NONE && cty == q_req.vtype) begin
              e_ok = 1'b1;
              e_ra = cx;
              if (q_req.vtype == T_VEC2) e_rb = cy;
            end
          end
          OP_TTL: begin
            ent_we = 1'b1;
            w_ttl = q_req.a;
            e_ok = 1'b1;
          end
          OP_DIRTY_Q: begin
            e_ok = 1'b1;
            e_dq = dirty_r[ix];
          end
          OP_DIRTY_CLR: begin
            ent_we = 1'b1;
            w_dirty = 1'b0;
            e_ok = 1'b1;
          end
          default: ;
        endcase
      end
    end else if (st_r == BK_TICK_WR) begin
      ent_we = 1'b1;
      if ($signed(cttl) > 0) begin
        w_ttl = sat_sub(cttl, q_req.a);
        if ($signed(w_ttl) <= 0) begin
          w_ty = T_NONE;
          w_dirty = 1'b1;
        end
      end
      if (w_ty == T_TIMER && $signed(cx) > 0) begin
        w_vx = sat_sub(cx, q_req.a);
        if ($signed(w_vx) < 0) begin
          w_vx = '0;
          w_dirty = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= BK_IDLE;
      used_r  <= '0;
      dirty_r <= '0;
      valid_r <= '0;
      ok_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        BK_IDLE: begin
          idx_r   <= '0;
          found_r <= 1'b0;
          ok_r    <= (q_req.op == OP_TICK) && !q_reject;
          dq_r    <= 1'b0;
          ra_r    <= '0;
          rb_r    <= '0;
        end
        BK_SEARCH: begin
          // cycle at index 0 only issues the first read
          if (st_nxt == BK_RD) begin
            found_r <= (idx_r < used_r) && (tag_q == q_req.key);
            if (!(idx_r < used_r && tag_q == q_req.key)) idx_r <= used_r;
          end else if (idx_r == '0 && !found_r) begin
            found_r <= 1'b1;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        BK_EXEC: begin
          ok_r <= e_ok;
          dq_r <= e_dq;
          ra_r <= e_ra;
          rb_r <= e_rb;
          if (add_new) used_r <= used_r + CW'(1);
          if (ent_we) begin
            dirty_r[ix] <= w_dirty;
            valid_r[ix] <= 1'b1;
          end
        end
        BK_TICK_WR: begin
          dirty_r[ix] <= w_dirty;
          valid_r[ix] <= 1'b1;
          idx_r <= idx_r + CW'(1);
        end
        default: ;
      endcase
    end
  end

  // search read address runs one ahead of the compare
  logic [IW-1:0] rd_ix;
  always_comb begin
    rd_ix = ix;
    if (st_r == BK_SEARCH && !(idx_r == '0 && !found_r)) rd_ix = IW'(idx_r + CW'(1));
  end

  always_ff @(posedge clk) begin
    tag_q <= tag_mem[rd_ix];
    vx_q  <= vx_mem[ix];
    vy_q  <= vy_mem[ix];
    ib_q  <= ib_mem[ix];
    fb_q  <= fb_mem[ix];
    ttl_q <= ttl_mem[ix];
    ty_q  <= ty_mem[ix];
    if (tag_we) tag_mem[ix] <= q_req.key;
    if (ent_we) begin
      vx_mem[ix]  <= w_vx;
      vy_mem[ix]  <= w_vy;
      ib_mem[ix]  <= w_ib;
      fb_mem[ix]  <= w_fb;
      ttl_mem[ix] <= w_ttl;
      ty_mem[ix]  <= w_ty;
    end
  end

  assign q_pop     = (st_r == BK_DONE);
  assign res_valid = (st_r == BK_DONE);
  assign res_ok    = ok_r;
  assign res_a     = ra_r;
  assign res_b     = rb_r;
  assign res_dirty = dq_r;
endmodule

@@ sv/keyed_typed_value_table.sv @@
// keyed_typed_value_table: top level joining the request queue and the executor.
// Depends on ktvt_pkg, ktvt_front, ktvt_back.
//
// Usage: drive the in_ ports and raise start; a request is taken at an edge
// where start is high and busy is low. A two-entry queue holds requests while
// the executor works, so busy rises only when the queue is full.
// Each request yields exactly one result: out_valid is high for one cycle with
// out_ok, out_read_a, out_read_b and out_dirty_state. The receiver cannot stall.
// A lookup scans the used entries one per cycle through the tag memory read
// port; a tick walks the used entries, reading each and then writing it back;
// a rejected set needs no lookup. The executor finishes one request before it
// takes the next from the queue.
// Reset (rst_n low, synchronous) empties the table and the queue; entries
// read as type none with zero values until written.
module keyed_typed_value_table #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_key,
  input  logic [2:0]  in_value_type,
  input  logic [1:0]  in_policy,
  input  logic signed [31:0] in_value_a,
  input  logic signed [31:0] in_value_b,
  output logic        out_valid,
  output logic        out_ok,
  output logic signed [31:0] out_read_a,
  output logic signed [31:0] out_read_b,
  output logic        out_dirty_state
);
  import ktvt_pkg::*;

  req_t req_in, q_req;
  logic q_valid, q_reject, q_pop;
  logic [31:0] ra, rb;

  always_comb begin
    req_in.op     = op_t'(in_operation);
    req_in.key    = in_key;
    req_in.vtype  = in_value_type;
    req_in.policy = in_policy;
    req_in.a      = in_value_a;
    req_in.b      = in_value_b;
  end

  ktvt_front u_front (
    .clk, .rst_n, .start, .req_in, .busy,
    .q_valid, .q_req, .q_reject, .q_pop
  );

  ktvt_back #(.CAPACITY(CAPACITY)) u_back (
    .clk, .rst_n, .q_valid, .q_req, .q_reject, .q_pop,
    .res_valid(out_valid), .res_ok(out_ok), .res_a(ra), .res_b(rb),
    .res_dirty(out_dirty_state)
  );

  assign out_read_a = ra;
  assign out_read_b = rb;
endmodule

@@ tb/sv/testbench.sv @@
// testbench: drives the keyed typed value table with directed and random requests
// and checks every result against a behavioural model of the table.
// Depends on ktvt_pkg and keyed_typed_value_table.
`timescale 1ns / 100ps

module testbench;
  import ktvt_pkg::*;

  localparam int DEPTH = 32;

  typedef struct {
    logic        ok;
    logic [31:0] ra;
    logic [31:0] rb;
    logic        ds;
  } resp_t;

  class table_scoreboard;
    logic [31:0] tag [DEPTH];
    logic [2:0]  typ [DEPTH];
    logic [31:0] vx [DEPTH];
    logic [31:0] vy [DEPTH];
    logic [31:0] ibase [DEPTH];
    logic [31:0] fbase [DEPTH];
    logic [31:0] ttl [DEPTH];
    logic        dirty [DEPTH];
    int          used;
    resp_t       pending[$];
    int          errors;

    function void clear();
      for (int i = 0; i < DEPTH; i++) begin
        tag[i] = '0; typ[i] = T_NONE; vx[i] = '0; vy[i] = '0;
        ibase[i] = '0; fbase[i] = '0; ttl[i] = '0; dirty[i] = 1'b0;
      end
      used = 0;
      errors = 0;
      pending.delete();
    endfunction

    function int lookup(logic [31:0] k);
      for (int i = 0; i < used; i++)
        if (tag[i] == k) return i;
      return -1;
    endfunction

    function int lookup_or_append(logic [31:0] k);
      int i;
      i = lookup(k);
      if (i >= 0) return i;
      if (used >= DEPTH) return -1;
      tag[used] = k;
      used++;
      return used - 1;
    endfunction

    function logic [31:0] sat(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function void note_request(req_t r);
      resp_t e;
      int i;
      logic changed, fx;
      logic signed [31:0] cur, a;
      e = '{1'b0, 32'h0, 32'h0, 1'b0};
      a = r.a;
      case (r.op)
        OP_SET: begin
          if (r.vtype != T_NONE && r.vtype <= T_TIMER) begin
            i = lookup_or_append(r.key);
            if (i >= 0) begin
              typ[i] = r.vtype;
              vx[i] = (r.vtype == T_BOOL) ? {31'h0, a != 0} : a;
              if (r.vtype == T_VEC2) vy[i] = r.b;
              if (r.vtype == T_INT) ibase[i] = a;
              if (r.vtype == T_FIXED) fbase[i] = a;
              dirty[i] = 1'b1;
              e.ok = 1'b1;
            end
          end
        end
        OP_INT_WR, OP_FIX_WR: begin
          fx = (r.op == OP_FIX_WR);
          i = lookup_or_append(r.key);
          if (i >= 0) begin
            if (typ[i] != (fx ? T_FIXED : T_INT)) begin
              typ[i] = fx ? T_FIXED : T_INT;
              vx[i] = fx ? fbase[i] : ibase[i];
            end
            cur = vx[i];
            changed = 1'b1;
            case (r.policy)
              POL_SET: cur = a;
              POL_MAX: if (a > cur) cur = a; else changed = 1'b0;
              POL_MIN: if (a < cur) cur = a; else changed = 1'b0;
              default: cur = fx ? sat(longint'(cur) + longint'(a)) : cur + a;
            endcase
            vx[i] = cur;
            if (fx) fbase[i] = cur; else ibase[i] = cur;
            if (changed) dirty[i] = 1'b1;
            e.ok = fx ? changed : 1'b1;
          end
        end
        OP_GET: begin
          i = lookup(r.key);
          if (i >= 0 && r.vtype != T_NONE && typ[i] == r.vtype) begin
            e.ok = 1'b1;
            e.ra = vx[i];
            if (r.vtype == T_VEC2) e.rb = vy[i];
          end
        end
        OP_TTL: begin
          i = lookup(r.key);
          if (i >= 0) begin
            ttl[i] = a;
            e.ok = 1'b1;
          end
        end
        OP_TICK: begin
          for (int k = 0; k < used; k++) begin
            if ($signed(ttl[k]) > 0) begin
              ttl[k] = sat(longint'($signed(ttl[k])) - longint'(a));
              if ($signed(ttl[k]) <= 0) begin
                typ[k] = T_NONE;
                dirty[k] = 1'b1;
              end
            end
            if (typ[k] == T_TIMER && $signed(vx[k]) > 0) begin
              cur = sat(longint'($signed(vx[k])) - longint'(a));
              if (cur < 0) begin
                cur = 0;
                dirty[k] = 1'b1;
              end
              vx[k] = cur;
            end
          end
          e.ok = 1'b1;
        end
        OP_DIRTY_Q: begin
          i = lookup(r.key);
          if (i >= 0) begin
            e.ok = 1'b1;
            e.ds = dirty[i];
          end
        end
        default: begin
          i = lookup(r.key);
          if (i >= 0) begin
            dirty[i] = 1'b0;
            e.ok = 1'b1;
          end
        end
      endcase
      pending.push_back(e);
    endfunction

    function void check_result(resp_t got);
      resp_t e;
      if (pending.size() == 0) begin
        $error("unexpected result ok=%0b a=%h", got.ok, got.ra);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.ok !== e.ok) begin
        $error("ok: expected %0b, got %0b", e.ok, got.ok); errors++;
      end
      if (got.ra !== e.ra) begin
        $error("read_a: expected %h, got %h", e.ra, got.ra); errors++;
      end
      if (got.rb !== e.rb) begin
        $error("read_b: expected %h, got %h", e.rb, got.rb); errors++;
      end
      if (got.ds !== e.ds) begin
        $error("dirty_state: expected %0b, got %0b", e.ds, got.ds); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_operation = '0;
  logic [31:0] in_key = '0;
  logic [2:0]  in_value_type = '0;
  logic [1:0]  in_policy = '0;
  logic signed [31:0] in_value_a = '0;
  logic signed [31:0] in_value_b = '0;
  logic        out_valid;
  logic        out_ok;
  logic signed [31:0] out_read_a;
  logic signed [31:0] out_read_b;
  logic        out_dirty_state;

  table_scoreboard table_model;
  logic [31:0] key_pool [8];

  always #5 clk = ~clk;

  keyed_typed_value_table uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_key(in_key), .in_value_type(in_value_type),
    .in_policy(in_policy), .in_value_a(in_value_a), .in_value_b(in_value_b),
    .out_valid(out_valid), .out_ok(out_ok), .out_read_a(out_read_a),
    .out_read_b(out_read_b), .out_dirty_state(out_dirty_state)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid)
      table_model.check_result('{out_ok, out_read_a, out_read_b, out_dirty_state});
  end

  // start stays high between back-to-back requests; it drops for a gap and in drain
  task automatic send_request(op_t op, logic [31:0] k, logic [2:0] vt, logic [1:0] pol,
                              logic [31:0] a, logic [31:0] b, int gap);
    req_t r;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    r = '{op, k, vt, pol, a, b};
    start <= 1'b1;
    in_operation <= op; in_key <= k; in_value_type <= vt;
    in_policy <= pol; in_value_a <= a; in_value_b <= b;
    do @(posedge clk); while (busy);
    table_model.note_request(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (table_model.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 8);
      3: return -$urandom_range(0, 8);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_key(int fresh_pct);
    if ($urandom_range(0, 99) < fresh_pct) return $urandom();
    return key_pool[3'($urandom_range(0, 7))];
  endfunction

  task automatic random_phase(int count, int fresh_pct, int max_gap);
    op_t op;
    for (int n = 0; n < count; n++) begin
      op = op_t'($urandom_range(0, 7));
      send_request(op, pick_key(fresh_pct), 3'($urandom_range(0, 7)),
                   2'($urandom_range(0, 3)),
                   (op == OP_TICK && $urandom_range(0, 1)) ? $urandom_range(0, 3) << 16
                                                           : pick_value(),
                   pick_value(), $urandom_range(0, max_gap));
    end
  endtask

  initial begin
    table_model = new();
    table_model.clear();
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = 32'h0; key_pool[1] = 32'hffff_ffff;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: rejected sets, every type, policies, saturation, ttl expiry, timers
    send_request(OP_GET, key_pool[0], T_INT, POL_SET, 0, 0, 0);
    send_request(OP_SET, key_pool[0], T_NONE, POL_SET, 5, 0, 0);
    send_request(OP_SET, key_pool[0], 3'd7, POL_SET, 5, 0, 0);
    send_request(OP_DIRTY_Q, key_pool[0], T_NONE, POL_SET, 0, 0, 0);
    send_request(OP_SET, key_pool[0], T_INT, POL_SET, 32'h7fff_ffff, 0, 0);
    send_request(OP_INT_WR, key_pool[0], T_NONE, POL_ACC, 1, 0, 0);
    send_request(OP_GET, key_pool[0], T_INT, POL_SET, 0, 0, 0);
    send_request(OP_FIX_WR, key_pool[0], T_NONE, POL_SET, 32'h7fff_0000, 0, 0);
    send_request(OP_FIX_WR, key_pool[0], T_NONE, POL_ACC, 32'h7fff_ffff, 0, 0);
    send_request(OP_FIX_WR, key_pool[0], T_NONE, POL_MAX, 5, 0, 0);
    send_request(OP_FIX_WR, key_pool[0], T_NONE, POL_MIN, 32'h8000_0000, 0, 0);
    send_request(OP_INT_WR, key_pool[0], T_NONE, POL_MIN, 3, 0, 0);
    send_request(OP_SET, key_pool[1], T_VEC2, POL_SET, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_request(OP_GET, key_pool[1], T_VEC2, POL_SET, 0, 0, 0);
    send_request(OP_SET, key_pool[2], T_BOOL, POL_SET, 32'h8000_0000, 0, 0);
    send_request(OP_SET, key_pool[3], T_HANDLE, POL_SET, 32'hdead_beef, 0, 0);
    send_request(OP_SET, key_pool[4], T_TIMER, POL_SET, 32'h0003_0000, 0, 0);
    send_request(OP_TTL, key_pool[2], T_NONE, POL_SET, 32'h0001_0000, 0, 0);
    send_request(OP_TICK, 0, T_NONE, POL_SET, 32'h0002_0000, 0, 0);
    send_request(OP_TICK, 0, T_NONE, POL_SET, 32'h8000_0000, 0, 0);
    send_request(OP_GET, key_pool[4], T_TIMER, POL_SET, 0, 0, 0);
    send_request(OP_DIRTY_CLR, key_pool[2], T_NONE, POL_SET, 0, 0, 0);
    send_request(OP_DIRTY_Q, key_pool[2], T_NONE, POL_SET, 0, 0, 0);
    send_request(OP_GET, key_pool[2], T_BOOL, POL_SET, 0, 0, 0);

    random_phase(300, 5, 19);
    drain();
    random_phase(50, 0, 0);
    random_phase(200, 60, 3);   // fills the table, then exercises the full case
    drain();
    random_phase(400, 3, 19);
    drain();
    repeat (100) @(posedge clk);
    if (table_model.errors == 0 && table_model.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
sv/ktvt_pkg.sv
sv/ktvt_front.sv
sv/ktvt_back.sv
sv/keyed_typed_value_table.sv
tb/sv/testbench.sv
